/* hw/rtl/lsia_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIFO stack package
// Sizes, command and status codes, and the decoded operation that passes
// from the front end to the back end of the stack.
// ----------------------------------------------------------------------------
package lsia_pkg;

    localparam int Depth      = 16;
    localparam int DataW      = 8;
    localparam int CountW     = $clog2(Depth + 1);
    localparam int AddrW      = $clog2(Depth);
    localparam int IndexW     = 4;
    localparam int CmdW       = 3;
    localparam int StatusW    = 2;
    localparam int CmpW       = (CountW > IndexW) ? CountW : IndexW;
    localparam int QueueDepth = 2;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    typedef enum logic [CmdW-1:0] {
        CMD_PUSH   = CmdW'(0),
        CMD_POP    = CmdW'(1),
        CMD_READ   = CmdW'(2),
        CMD_UPDATE = CmdW'(3),
        CMD_SWAP   = CmdW'(4)
    } cmd_t;

    typedef enum logic [StatusW-1:0] {
        ST_OK    = StatusW'(0),
        ST_FULL  = StatusW'(1),
        ST_EMPTY = StatusW'(2),
        ST_RANGE = StatusW'(3)
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_WRITE,
        OP_READ,
        OP_SWAP
    } op_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_SWAP_A,
        BK_SWAP_B
    } back_state_t;

    typedef struct packed {
        op_kind_t              kind;
        logic [AddrW-1:0]      addr_a;
        logic [AddrW-1:0]      addr_b;
        logic [DataW-1:0]      data;
        status_t               status;
        logic [CountW-1:0]     count;
    } op_t;

endpackage

/* hw/rtl/lsia_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module lsia_ram #(
    parameter int Width = 8,
    parameter int Depth = 16,
    localparam int AddrW = $clog2(Depth)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [Width-1:0] wdata,
    input  logic             re,
    input  logic [AddrW-1:0] raddr_a,
    input  logic [AddrW-1:0] raddr_b,
    output logic [Width-1:0] rdata_a,
    output logic [Width-1:0] rdata_b
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

/* hw/rtl/lsia_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIFO stack front end
// Accepts commands, keeps the word count and decides status, store slots and
// the count after each command.
// ----------------------------------------------------------------------------
module lsia_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [lsia_pkg::CmdW-1:0]    s_cmd,
    input  logic [lsia_pkg::DataW-1:0]   s_data_in,
    input  logic [lsia_pkg::IndexW-1:0]  s_index_a,
    input  logic [lsia_pkg::IndexW-1:0]  s_index_b,
    input  logic                         q_full,
    output logic                         q_push,
    output lsia_pkg::op_t                q_op
);

    logic [lsia_pkg::CountW-1:0] count_reg;
    logic [lsia_pkg::CountW-1:0] count_next;
    logic [lsia_pkg::CmpW-1:0]   cnt_ext;
    logic [lsia_pkg::CmpW-1:0]   ia_ext;
    logic [lsia_pkg::CmpW-1:0]   ib_ext;
    logic [lsia_pkg::CmpW-1:0]   slot_a;
    logic [lsia_pkg::CmpW-1:0]   slot_b;
    logic [lsia_pkg::CountW-1:0] top_slot;
    logic                        empty;
    logic                        full;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        cnt_ext  = lsia_pkg::CmpW'(count_reg);
        ia_ext   = lsia_pkg::CmpW'(s_index_a);
        ib_ext   = lsia_pkg::CmpW'(s_index_b);
        slot_a   = cnt_ext - lsia_pkg::CmpW'(1) - ia_ext;
        slot_b   = cnt_ext - lsia_pkg::CmpW'(1) - ib_ext;
        top_slot = count_reg - lsia_pkg::CountW'(1);
        empty    = (count_reg == '0);
        full     = (count_reg >= lsia_pkg::CountW'(lsia_pkg::Depth));

        count_next    = count_reg;
        q_op.kind     = lsia_pkg::OP_NONE;
        q_op.addr_a   = slot_a[lsia_pkg::AddrW-1:0];
        q_op.addr_b   = slot_b[lsia_pkg::AddrW-1:0];
        q_op.data     = s_data_in;
        q_op.status   = lsia_pkg::ST_OK;

        case (lsia_pkg::cmd_t'(s_cmd))
            lsia_pkg::CMD_PUSH: begin
                if (full) begin
                    q_op.status = lsia_pkg::ST_FULL;
                end else begin
                    q_op.kind   = lsia_pkg::OP_WRITE;
                    q_op.addr_a = count_reg[lsia_pkg::AddrW-1:0];
                    count_next  = count_reg + lsia_pkg::CountW'(1);
                end
            end
            lsia_pkg::CMD_POP: begin
                if (empty) begin
                    q_op.status = lsia_pkg::ST_EMPTY;
                end else begin
                    q_op.kind   = lsia_pkg::OP_READ;
                    q_op.addr_a = top_slot[lsia_pkg::AddrW-1:0];
                    count_next  = top_slot;
                end
            end
            lsia_pkg::CMD_READ, lsia_pkg::CMD_UPDATE: begin
                if (empty) begin
                    q_op.status = lsia_pkg::ST_EMPTY;
                end else if (ia_ext >= cnt_ext) begin
                    q_op.status = lsia_pkg::ST_RANGE;
                end else if (lsia_pkg::cmd_t'(s_cmd) == lsia_pkg::CMD_READ) begin
                    q_op.kind = lsia_pkg::OP_READ;
                end else begin
                    q_op.kind = lsia_pkg::OP_WRITE;
                end
            end
            lsia_pkg::CMD_SWAP: begin
                if (empty) begin
                    q_op.status = lsia_pkg::ST_EMPTY;
                end else if (ia_ext >= cnt_ext || ib_ext >= cnt_ext) begin
                    q_op.status = lsia_pkg::ST_RANGE;
                end else begin
                    q_op.kind = lsia_pkg::OP_SWAP;
                end
            end
            default: begin
                q_op.kind = lsia_pkg::OP_NONE;
            end
        endcase

        q_op.count = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (q_push) begin
            count_reg <= count_next;
        end
    end

endmodule

/* hw/rtl/lsia_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIFO stack operation queue
// A short queue of decoded operations between the front and back ends.
// ----------------------------------------------------------------------------
module lsia_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_push,
    input  lsia_pkg::op_t q_op,
    output logic          q_full,
    input  logic          q_pop,
    output logic          q_valid,
    output lsia_pkg::op_t q_head
);

    lsia_pkg::op_t                  entry_reg [lsia_pkg::QueueDepth];
    logic [lsia_pkg::QueuePtrW-1:0] wr_ptr_reg;
    logic [lsia_pkg::QueuePtrW-1:0] wr_ptr_next;
    logic [lsia_pkg::QueuePtrW-1:0] rd_ptr_reg;
    logic [lsia_pkg::QueuePtrW-1:0] rd_ptr_next;
    logic [lsia_pkg::QueueCntW-1:0] fill_reg;
    logic [lsia_pkg::QueueCntW-1:0] fill_next;

    assign q_full  = (fill_reg == lsia_pkg::QueueCntW'(lsia_pkg::QueueDepth));
    assign q_valid = (fill_reg != '0);
    assign q_head  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (q_push) begin
            wr_ptr_next = (wr_ptr_reg == lsia_pkg::QueuePtrW'(lsia_pkg::QueueDepth - 1))
                        ? '0 : wr_ptr_reg + lsia_pkg::QueuePtrW'(1);
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == lsia_pkg::QueuePtrW'(lsia_pkg::QueueDepth - 1))
                        ? '0 : rd_ptr_reg + lsia_pkg::QueuePtrW'(1);
        end
        if (q_push && !q_pop) begin
            fill_next = fill_reg + lsia_pkg::QueueCntW'(1);
        end else if (q_pop && !q_push) begin
            fill_next = fill_reg - lsia_pkg::QueueCntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push) begin
            entry_reg[wr_ptr_reg] <= q_op;
        end
    end

endmodule

/* hw/rtl/lsia_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIFO stack back end
// Carries out decoded operations on the stack RAM and holds the result beat
// in an output register.
// ----------------------------------------------------------------------------
module lsia_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  lsia_pkg::op_t                 q_head,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lsia_pkg::StatusW-1:0]  m_status,
    output logic [lsia_pkg::DataW-1:0]    m_data_out,
    output logic [lsia_pkg::CountW-1:0]   m_count
);

    lsia_pkg::back_state_t         state_reg;
    lsia_pkg::back_state_t         state_next;
    lsia_pkg::op_t                 op_reg;
    lsia_pkg::op_t                 op_next;
    logic                          m_valid_reg;
    logic                          m_valid_next;
    lsia_pkg::status_t             m_status_reg;
    lsia_pkg::status_t             m_status_next;
    logic [lsia_pkg::DataW-1:0]    m_data_reg;
    logic [lsia_pkg::DataW-1:0]    m_data_next;
    logic [lsia_pkg::CountW-1:0]   m_count_reg;
    logic [lsia_pkg::CountW-1:0]   m_count_next;

    logic                          out_free;
    logic                          out_load;
    logic                          ram_we;
    logic [lsia_pkg::AddrW-1:0]    ram_waddr;
    logic [lsia_pkg::DataW-1:0]    ram_wdata;
    logic                          ram_re;
    logic [lsia_pkg::AddrW-1:0]    ram_raddr_a;
    logic [lsia_pkg::AddrW-1:0]    ram_raddr_b;
    logic [lsia_pkg::DataW-1:0]    ram_rdata_a;
    logic [lsia_pkg::DataW-1:0]    ram_rdata_b;

    lsia_ram #(
        .Width (lsia_pkg::DataW),
        .Depth (lsia_pkg::Depth)
    ) u_store (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (ram_re),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    assign out_free   = !m_valid_reg || m_ready;
    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_data_out = m_data_reg;
    assign m_count    = m_count_reg;

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        q_pop         = 1'b0;
        out_load      = 1'b0;
        m_status_next = m_status_reg;
        m_data_next   = m_data_reg;
        m_count_next  = m_count_reg;
        ram_we        = 1'b0;
        ram_waddr     = q_head.addr_a;
        ram_wdata     = q_head.data;
        ram_re        = 1'b0;
        ram_raddr_a   = q_head.addr_a;
        ram_raddr_b   = q_head.addr_b;

        case (state_reg)
            lsia_pkg::BK_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop   = 1'b1;
                    op_next = q_head;
                    case (q_head.kind)
                        lsia_pkg::OP_WRITE: begin
                            ram_we        = 1'b1;
                            out_load      = 1'b1;
                            m_status_next = q_head.status;
                            m_data_next   = '0;
                            m_count_next  = q_head.count;
                        end
                        lsia_pkg::OP_READ: begin
                            ram_re     = 1'b1;
                            state_next = lsia_pkg::BK_READ;
                        end
                        lsia_pkg::OP_SWAP: begin
                            ram_re     = 1'b1;
                            state_next = lsia_pkg::BK_SWAP_A;
                        end
                        default: begin
                            out_load      = 1'b1;
                            m_status_next = q_head.status;
                            m_data_next   = '0;
                            m_count_next  = q_head.count;
                        end
                    endcase
                end
            end
            lsia_pkg::BK_READ: begin
                out_load      = 1'b1;
                m_status_next = op_reg.status;
                m_data_next   = ram_rdata_a;
                m_count_next  = op_reg.count;
                state_next    = lsia_pkg::BK_IDLE;
            end
            lsia_pkg::BK_SWAP_A: begin
                ram_we     = 1'b1;
                ram_waddr  = op_reg.addr_a;
                ram_wdata  = ram_rdata_b;
                state_next = lsia_pkg::BK_SWAP_B;
            end
            lsia_pkg::BK_SWAP_B: begin
                ram_we        = 1'b1;
                ram_waddr     = op_reg.addr_b;
                ram_wdata     = ram_rdata_a;
                out_load      = 1'b1;
                m_status_next = op_reg.status;
                m_data_next   = '0;
                m_count_next  = op_reg.count;
                state_next    = lsia_pkg::BK_IDLE;
            end
            default: begin
                state_next = lsia_pkg::BK_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lsia_pkg::BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        m_status_reg <= m_status_next;
        m_data_reg   <= m_data_next;
        m_count_reg  <= m_count_next;
    end

endmodule

/* hw/rtl/lifo_stack_with_indexed_access_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIFO stack with indexed access
// Each command beat on the s_ channel (push, pop, read, update or swap, with
// a data word and two depth indices counted from the top) gives exactly one
// result beat on the m_ channel with a status, a data word and the count of
// stored words after the command. Results leave in command order.
// The front end accepts a beat whenever its two-entry operation queue has
// room and settles status and count at once; the back end then works on the
// stack RAM. Push, update, errors and unused codes go from the queue to the
// output register, one beat per cycle while m_ready is high; pop and read
// pass through BK_READ for the registered RAM read, and swap through
// BK_SWAP_A and BK_SWAP_B for two writes through the single RAM write port.
// The back end takes the next operation only once back in its idle state.
// When the receiver holds m_ready low the result stays in the output
// register, the back end stops and the queue fills, after which s_ready
// drops. Reset empties the stack and the queue and clears m_valid; the RAM
// contents are left as they are, as only slots below the count are read.
// ----------------------------------------------------------------------------
module lifo_stack_with_indexed_access_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lsia_pkg::CmdW-1:0]     s_cmd,
    input  logic [lsia_pkg::DataW-1:0]    s_data_in,
    input  logic [lsia_pkg::IndexW-1:0]   s_index_a,
    input  logic [lsia_pkg::IndexW-1:0]   s_index_b,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lsia_pkg::StatusW-1:0]  m_status,
    output logic [lsia_pkg::DataW-1:0]    m_data_out,
    output logic [lsia_pkg::CountW-1:0]   m_count
);

    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_valid;
    lsia_pkg::op_t q_op;
    lsia_pkg::op_t q_head;

    lsia_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .s_data_in (s_data_in),
        .s_index_a (s_index_a),
        .s_index_b (s_index_b),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_op      (q_op)
    );

    lsia_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_op    (q_op),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_valid (q_valid),
        .q_head  (q_head)
    );

    lsia_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_data_out (m_data_out),
        .m_count    (m_count)
    );

endmodule

/* hw/rtl/lsia_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIFO stack port checker
// Watches the ports of the stack for protocol and result consistency.
// ----------------------------------------------------------------------------
module lsia_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [lsia_pkg::StatusW-1:0]  m_status,
    input  logic [lsia_pkg::DataW-1:0]    m_data_out,
    input  logic [lsia_pkg::CountW-1:0]   m_count
);

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_data_out)
                                && $stable(m_count))
        else $error("Result beat changed while stalled.");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_count <= lsia_pkg::CountW'(lsia_pkg::Depth))
        else $error("Count exceeds the stack depth.");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == lsia_pkg::ST_FULL
            |-> m_count == lsia_pkg::CountW'(lsia_pkg::Depth))
        else $error("Full status with a stack that is not full.");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == lsia_pkg::ST_EMPTY |-> m_count == '0)
        else $error("Empty status with a stack that is not empty.");

    a_error_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != lsia_pkg::ST_OK |-> m_data_out == '0)
        else $error("Failed command returned a non-zero word.");

endmodule

bind lifo_stack_with_indexed_access_top lsia_checker u_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_status   (m_status),
    .m_data_out (m_data_out),
    .m_count    (m_count)
);
